/* hdl/ufsd_pkg.sv */
package ufsd_pkg;

    localparam int MAX_FRAME = 64;
    localparam int POS_W     = 7;
    localparam int STATUS_W  = 5;
    localparam int TIMER_W   = 16;

    localparam logic [7:0] START_BYTE  = 8'hAA;
    localparam logic [7:0] END_BYTE    = 8'h55;
    localparam logic [7:0] TYPE_STATUS = 8'hB0;
    localparam logic [7:0] TYPE_ERROR  = 8'hB5;
    localparam logic [7:0] CLASS_WATER = 8'h0E;
    localparam logic [7:0] FLAG_WATER  = 8'h40;
    localparam logic [7:0] FLAG_TRAY   = 8'h80;

    localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd15000;
    localparam logic [TIMER_W-1:0] PERIOD_RESET  = 16'd1000;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_TIMEOUT = 1'b0,
        CFG_PERIOD  = 1'b1
    } cfg_index_t;

    // Item kinds on the input tuser bit
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef logic [STATUS_W-1:0] status_t;

    // Status indexes, named by their file code
    localparam status_t ST_CODE_01 = 5'd0;
    localparam status_t ST_CODE_02 = 5'd1;
    localparam status_t ST_CODE_03 = 5'd2;
    localparam status_t ST_CODE_04 = 5'd3;
    localparam status_t ST_CODE_05 = 5'd4;
    localparam status_t ST_CODE_06 = 5'd5;
    localparam status_t ST_CODE_07 = 5'd6;
    localparam status_t ST_CODE_08 = 5'd7;
    localparam status_t ST_CODE_09 = 5'd8;
    localparam status_t ST_CODE_10 = 5'd9;
    localparam status_t ST_CODE_11 = 5'd10;
    localparam status_t ST_CODE_12 = 5'd11;
    localparam status_t ST_CODE_13 = 5'd12;
    localparam status_t ST_CODE_14 = 5'd13;
    localparam status_t ST_CODE_15 = 5'd14;
    localparam status_t ST_CODE_17 = 5'd15;
    localparam status_t ST_CODE_18 = 5'd16;
    localparam status_t ST_CODE_20 = 5'd17;
    localparam status_t ST_CODE_21 = 5'd18;
    localparam status_t ST_CODE_22 = 5'd19;
    localparam status_t ST_CODE_23 = 5'd20;
    localparam status_t ST_CODE_24 = 5'd21;
    localparam status_t ST_CODE_25 = 5'd22;
    localparam status_t ST_CODE_30 = 5'd23;
    localparam status_t ST_CODE_31 = 5'd24;
    localparam status_t ST_CODE_32 = 5'd25;
    localparam status_t ST_CODE_33 = 5'd26;
    localparam status_t ST_CODE_34 = 5'd27;
    localparam status_t ST_CODE_35 = 5'd28;
    localparam status_t ST_CODE_36 = 5'd29;
    localparam status_t ST_CODE_37 = 5'd30;

    localparam status_t ST_OFF = ST_CODE_02;

    typedef struct packed {
        logic [1:0] cnt;
        status_t    first;
        status_t    second;
    } decode_t;

    // Decode a closed frame of the given size from its captured bytes
    function automatic decode_t decode_frame(
        input logic [POS_W-1:0] size,
        input logic [7:0]       type_b,
        input logic [7:0]       class_b,
        input logic [7:0]       detail_b,
        input logic [7:0]       flags_b,
        input logic [7:0]       err_hi,
        input logic [7:0]       err_lo
    );
        decode_t d;
        d = '{cnt: 2'd0, first: ST_CODE_01, second: ST_CODE_01};
        if (size > POS_W'(4) && type_b == TYPE_STATUS) begin
            if (size >= POS_W'(12)) begin
                if (class_b == CLASS_WATER) begin
                    if (flags_b == 8'h00) begin
                        d.cnt   = 2'd1;
                        d.first = ST_CODE_20;
                    end
                    else begin
                        d.cnt    = 2'd2;
                        d.first  = ((flags_b & FLAG_WATER) != 8'h00) ? ST_CODE_22 : ST_CODE_17;
                        d.second = ((flags_b & FLAG_TRAY) != 8'h00) ? ST_CODE_23 : ST_CODE_18;
                    end
                end
                else if (class_b == 8'h06) begin
                    d.cnt   = 2'd1;
                    d.first = ST_CODE_21;
                end
                else if (class_b == 8'h0C) begin
                    if (detail_b == 8'h01) begin
                        d.cnt   = 2'd1;
                        d.first = ST_CODE_08;
                    end
                    else if (detail_b == 8'h02) begin
                        d.cnt   = 2'd1;
                        d.first = ST_CODE_15;
                    end
                end
                else if (class_b == 8'h07) begin
                    d.cnt = 2'd1;
                    unique case (detail_b)
                        8'h0E:   d.first = ST_CODE_09;
                        8'h0D:   d.first = ST_CODE_10;
                        8'h10:   d.first = ST_CODE_03;
                        8'h11:   d.first = ST_CODE_04;
                        8'h12:   d.first = ST_CODE_05;
                        8'h13:   d.first = ST_CODE_06;
                        8'h14:   d.first = ST_CODE_07;
                        8'h15:   d.first = ST_CODE_15;
                        default: d.cnt   = 2'd0;
                    endcase
                end
                else if (class_b == 8'h08) begin
                    d.cnt = 2'd1;
                    unique case (detail_b)
                        8'h0E:   d.first = ST_CODE_14;
                        8'h02:   d.first = ST_CODE_11;
                        8'h14:   d.first = ST_CODE_13;
                        8'h05:   d.first = ST_CODE_12;
                        8'h16:   d.first = ST_CODE_24;
                        8'h18:   d.first = ST_CODE_25;
                        default: d.cnt   = 2'd0;
                    endcase
                end
                else if (detail_b == 8'h00) begin
                    if (class_b == 8'h01) begin
                        d.cnt   = 2'd1;
                        d.first = ST_CODE_01;
                    end
                    else if (class_b == 8'h05) begin
                        d.cnt   = 2'd1;
                        d.first = ST_CODE_02;
                    end
                end
            end
        end
        else if (size > POS_W'(12) && type_b == TYPE_ERROR) begin
            if (err_hi == 8'h00) begin
                d.cnt = 2'd1;
                unique case (err_lo)
                    8'h00:   d.first = ST_CODE_30;
                    8'h0B:   d.first = ST_CODE_31;
                    8'hE6:   d.first = ST_CODE_32;
                    8'h80:   d.first = ST_CODE_33;
                    8'hCB:   d.first = ST_CODE_34;
                    8'hFF:   d.first = ST_CODE_35;
                    8'hA0:   d.first = ST_CODE_36;
                    default: d.cnt   = 2'd0;
                endcase
            end
            else if (err_hi == 8'h01) begin
                d.cnt   = 2'd1;
                d.first = ST_CODE_37;
            end
        end
        return d;
    endfunction

endpackage

/* hdl/uart_frame_status_decoder_top.sv */
// Frame status decoder for bytes sniffed from one side of a serial link.
// Input channel s_axis: tuser = 0 carries a received byte in tdata, tuser = 1
// is a one millisecond tick (tdata ignored). Output channel m_axis: tdata[4:0]
// is the status index, tlast marks the final status caused by one item.
// Configuration: cfg_we writes cfg_data to the register picked by cfg_index
// (0 = timeout in ms, 1 = check period in ms); write only while idle.
// An accepted item waits in the input register until the result queue has
// room for its results, which are then registered into the queue that
// drives m_axis.
// Throughput: one item per cycle while m_axis accepts. A frame end that
// decodes to two statuses holds the input register until the result queue
// has sent its first; items causing no result pass without using the output.
// Reset clears the frame hunter, captured bytes, timers and queues, and
// loads the register defaults (15000 ms timeout, 1000 ms check period).
// When m_axis stalls, up to two results wait in the result queue, one more
// item waits in the input register, and s_axis_tready drops after that.
module uart_frame_status_decoder_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [7:0]                 s_axis_tdata,   // [7:0] data_byte
    input  logic                       s_axis_tuser,   // [0] op
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [7:0]                 m_axis_tdata,   // [4:0] status, [7:5] zero
    output logic                       m_axis_tlast,
    input  logic                       cfg_we,
    input  ufsd_pkg::cfg_index_t       cfg_index,
    input  logic [ufsd_pkg::TIMER_W-1:0] cfg_data
);
    import ufsd_pkg::*;

    logic [TIMER_W-1:0] timeout_reg;
    logic [TIMER_W-1:0] period_reg;

    logic               in_valid_reg;
    logic               in_op_reg;
    logic [7:0]         in_byte_reg;

    logic [POS_W-1:0]   frame_pos_reg, frame_pos_next;
    logic [7:0]         type_reg, type_next;
    logic [7:0]         class_reg, class_next;
    logic [7:0]         detail_reg, detail_next;
    logic [7:0]         flags_reg, flags_next;
    logic [7:0]         err_hi_reg, err_hi_next;
    logic [7:0]         err_lo_reg, err_lo_next;
    logic [TIMER_W-1:0] since_check_reg, since_check_next;
    logic [TIMER_W-1:0] since_act_reg, since_act_next;

    logic [1:0]         out_cnt_reg, out_cnt_next;
    status_t            out0_reg, out0_next;
    status_t            out1_reg, out1_next;

    logic               advance;
    logic               pop;
    logic [POS_W-1:0]   pos_inc;
    logic               frame_end;
    decode_t            result;
    logic [TIMER_W-1:0] check_inc;
    logic [TIMER_W-1:0] act_inc;

    assign pop           = m_axis_tvalid && m_axis_tready;
    // Room for two results: queue empty, or its last entry leaves this cycle
    assign advance       = in_valid_reg &&
                           (out_cnt_reg == 2'd0 || (out_cnt_reg == 2'd1 && m_axis_tready));
    assign s_axis_tready = !in_valid_reg || advance;

    assign m_axis_tvalid = (out_cnt_reg != 2'd0);
    assign m_axis_tdata  = {{(8 - STATUS_W){1'b0}}, out0_reg};
    assign m_axis_tlast  = (out_cnt_reg == 2'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
            period_reg  <= PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TIMEOUT: timeout_reg <= cfg_data;
                CFG_PERIOD:  period_reg  <= cfg_data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_op_reg   <= s_axis_tuser;
            in_byte_reg <= s_axis_tdata;
        end
    end

    assign pos_inc   = frame_pos_reg + POS_W'(1);
    assign frame_end = (in_op_reg == OP_BYTE) && (frame_pos_reg != '0) &&
                       (in_byte_reg == END_BYTE);
    assign check_inc = (since_check_reg == '1) ? since_check_reg
                                               : since_check_reg + TIMER_W'(1);
    assign act_inc   = (since_act_reg == '1) ? since_act_reg
                                             : since_act_reg + TIMER_W'(1);

    always_comb
    begin
        frame_pos_next   = frame_pos_reg;
        type_next        = type_reg;
        class_next       = class_reg;
        detail_next      = detail_reg;
        flags_next       = flags_reg;
        err_hi_next      = err_hi_reg;
        err_lo_next      = err_lo_reg;
        since_check_next = since_check_reg;
        since_act_next   = since_act_reg;
        result           = '{cnt: 2'd0, first: ST_OFF, second: ST_OFF};

        if (in_op_reg == OP_BYTE)
        begin
            if (frame_pos_reg == '0)
            begin
                if (in_byte_reg == START_BYTE)
                    frame_pos_next = POS_W'(1);
            end
            else
            begin
                case (frame_pos_reg)
                    POS_W'(3):  type_next   = in_byte_reg;
                    POS_W'(6):  class_next  = in_byte_reg;
                    POS_W'(7):  detail_next = in_byte_reg;
                    POS_W'(9):  flags_next  = in_byte_reg;
                    POS_W'(10): err_hi_next = in_byte_reg;
                    POS_W'(11): err_lo_next = in_byte_reg;
                    default:    ;
                endcase
                if (frame_end)
                begin
                    frame_pos_next = '0;
                    since_act_next = '0;
                    result         = decode_frame(pos_inc, type_next, class_next,
                                                  detail_next, flags_next,
                                                  err_hi_next, err_lo_next);
                end
                else if (pos_inc >= POS_W'(MAX_FRAME))
                begin
                    // drop the overflowing frame, resume hunting
                    frame_pos_next = '0;
                end
                else
                begin
                    frame_pos_next = pos_inc;
                end
            end
        end
        else
        begin
            since_check_next = check_inc;
            since_act_next   = act_inc;
            if (check_inc > period_reg)
            begin
                since_check_next = '0;
                if (act_inc > timeout_reg)
                begin
                    since_act_next = '0;
                    result.cnt     = 2'd1;
                    result.first   = ST_OFF;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_pos_reg   <= '0;
            type_reg        <= '0;
            class_reg       <= '0;
            detail_reg      <= '0;
            flags_reg       <= '0;
            err_hi_reg      <= '0;
            err_lo_reg      <= '0;
            since_check_reg <= '0;
            since_act_reg   <= '0;
        end
        else if (advance)
        begin
            frame_pos_reg   <= frame_pos_next;
            type_reg        <= type_next;
            class_reg       <= class_next;
            detail_reg      <= detail_next;
            flags_reg       <= flags_next;
            err_hi_reg      <= err_hi_next;
            err_lo_reg      <= err_lo_next;
            since_check_reg <= since_check_next;
            since_act_reg   <= since_act_next;
        end
    end

    always_comb
    begin
        out_cnt_next = out_cnt_reg;
        out0_next    = out0_reg;
        out1_next    = out1_reg;
        if (advance)
        begin
            // queue is empty after this cycle's pop: load the new results
            out_cnt_next = result.cnt;
            out0_next    = result.first;
            out1_next    = result.second;
        end
        else if (pop)
        begin
            out_cnt_next = out_cnt_reg - 2'd1;
            out0_next    = out1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_cnt_reg <= '0;
        end
        else
        begin
            out_cnt_reg <= out_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out0_reg <= out0_next;
        out1_reg <= out1_next;
    end

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_cnt_reg != 2'd3)
        else $error("result queue count out of range");

    a_frame_bound: assert property (@(posedge clk) disable iff (!rst_n)
        frame_pos_reg < POS_W'(MAX_FRAME))
        else $error("frame position past the frame limit");

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg)
                                     && $stable(in_op_reg))
        else $error("held input item changed before processing");

    a_advance_room: assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> out_cnt_reg == 2'd0 || pop)
        else $error("result queue overwritten");

endmodule
